// ----- rtl/pot_pkg.sv -----
// ----------------------------------------------------------------------------
// pot_pkg
// shared constants, codes and types of the timer bank: sizes, command kinds,
// event codes and the words that travel along the row of timer cells
// ----------------------------------------------------------------------------
package pot_pkg;

    localparam int NUM_TIMERS  = 8;
    localparam int COUNT_WIDTH = 32;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int SU_W  = $clog2(NUM_TIMERS + 1);
    localparam int CMP_W = (SU_W > 3) ? SU_W : 3;

    // stream widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 8;

    // input kinds
    localparam logic [2:0] K_TICK   = 3'd0;
    localparam logic [2:0] K_CREATE = 3'd1;
    localparam logic [2:0] K_SETIV  = 3'd2;
    localparam logic [2:0] K_START  = 3'd3;
    localparam logic [2:0] K_STOP   = 3'd4;
    localparam logic [2:0] K_RELOAD = 3'd5;

    // result events
    localparam logic [1:0] EV_EXPIRED = 2'd0;
    localparam logic [1:0] EV_CREATED = 2'd1;
    localparam logic [1:0] EV_FULL    = 2'd2;

    // command broadcast to every cell
    typedef struct packed {
        logic                   valid;
        logic [2:0]             kind;
        logic [IDX_W-1:0]       addr;
        logic [COUNT_WIDTH-1:0] ival;
        logic                   one;
    } t_cmd;

    // expiry report handed down the row
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] slot;
    } t_hit;

endpackage

// ----- rtl/periodic_oneshot_timer_bank_unit.sv -----
// ----------------------------------------------------------------------------
// periodic_oneshot_timer_bank_unit
// bank of countdown timers built as a row of timer cells with a scan token
//
//   channel   | dir | handshake                     | payload
//   s_axis    | in  | i_s_axis_tvalid/o_s_axis_tready | tuser kind, tdata index,
//             |     |                               | interval, one-shot
//   m_axis    | out | o_m_axis_tvalid/i_m_axis_tready | tdata event, slot; tlast
//
// a tick sends a token down the row, one cell per cycle while the output is not
// stalled
// every word waits while a result sits unread
// expiry results leave in slot order, tlast on the final one of each word
// reset clears enables, token, fill count and output valid; stores need none
// ----------------------------------------------------------------------------
module periodic_oneshot_timer_bank_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [2:0] timer_index, [34:3] interval_value, [35] oneshot_flag
    input  logic [pot_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // [2:0] kind
    input  logic [pot_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [1:0] event_res, [4:2] slot
    output logic [pot_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    output logic                           o_m_axis_tlast
);
    import pot_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic            r_state;
    logic            n_state;
    logic [SU_W-1:0] r_slots_used;
    logic            r_out_valid;
    logic [1:0]      r_out_ev;
    logic [2:0]      r_out_slot;
    logic            r_out_last;

    logic       step;
    logic       acc;
    logic [2:0] kind;
    logic [2:0] tidx;
    logic       full;
    logic       addr_ok;
    logic       create_ok;
    logic       is_cmd;
    t_cmd       cmd;

    logic [NUM_TIMERS:0] tok_c;
    logic [NUM_TIMERS:0] pend_c;
    t_hit                hit_c [0:NUM_TIMERS];

    assign step = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && step;
    assign acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign kind = i_s_axis_tuser;
    assign tidx = i_s_axis_tdata[2:0];

    assign full      = (r_slots_used == SU_W'(NUM_TIMERS));
    assign addr_ok   = (CMP_W'(tidx) < CMP_W'(r_slots_used));
    assign create_ok = acc && (kind == K_CREATE) && !full;
    assign is_cmd    = (kind == K_SETIV) || (kind == K_START) ||
                       (kind == K_STOP) || (kind == K_RELOAD);

    always_comb begin
        cmd.valid = create_ok || (acc && is_cmd && addr_ok);
        cmd.kind  = kind;
        cmd.addr  = (kind == K_CREATE) ? IDX_W'(r_slots_used) : IDX_W'(tidx);
        cmd.ival  = COUNT_WIDTH'(i_s_axis_tdata[34:3]);
        cmd.one   = i_s_axis_tdata[35];
    end

    // token enters the first cell when a tick is taken
    assign tok_c[0]          = acc && (kind == K_TICK);
    assign pend_c[NUM_TIMERS] = 1'b0;
    assign hit_c[0]          = '0;

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        pot_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_cmd   (cmd),
            .i_step  (step),
            .i_tok   (tok_c[g]),
            .o_tok   (tok_c[g+1]),
            .i_pend  (pend_c[g+1]),
            .o_pend  (pend_c[g]),
            .i_hit   (hit_c[g]),
            .o_hit   (hit_c[g+1])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (tok_c[0]) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (tok_c[NUM_TIMERS] && step) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slots_used <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (create_ok) begin
                r_slots_used <= r_slots_used + SU_W'(1);
            end
            if (hit_c[NUM_TIMERS].valid || (acc && (kind == K_CREATE))) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit_c[NUM_TIMERS].valid) begin
            r_out_ev   <= EV_EXPIRED;
            r_out_slot <= 3'(hit_c[NUM_TIMERS].slot);
            r_out_last <= hit_c[NUM_TIMERS].last;
        end else if (acc && (kind == K_CREATE)) begin
            r_out_ev   <= full ? EV_FULL : EV_CREATED;
            r_out_slot <= full ? 3'd0 : 3'(r_slots_used);
            r_out_last <= 1'b1;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_slot, r_out_ev};
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ----- rtl/pot_cell.sv -----
// ----------------------------------------------------------------------------
// pot_cell
// one timer slot: period, remaining count, enable and one-shot bits; counts
// down when the scan token sits here and passes token, lookahead and expiry
// reports to its neighbors
// ----------------------------------------------------------------------------
module pot_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [pot_pkg::IDX_W-1:0] i_idx,
    input  pot_pkg::t_cmd      i_cmd,
    input  logic               i_step,
    input  logic               i_tok,
    output logic               o_tok,
    input  logic               i_pend,
    output logic               o_pend,
    input  pot_pkg::t_hit      i_hit,
    output pot_pkg::t_hit      o_hit
);
    import pot_pkg::*;

    logic                   r_tok;
    logic                   r_en;
    logic                   r_one;
    logic [COUNT_WIDTH-1:0] r_per;
    logic [COUNT_WIDTH-1:0] r_cnt;

    logic                   n_en;
    logic                   n_one;
    logic [COUNT_WIDTH-1:0] n_per;
    logic [COUNT_WIDTH-1:0] n_cnt;

    logic at_one;
    logic fire;
    logic expire;
    logic sel;

    assign at_one = (r_cnt == COUNT_WIDTH'(1));
    assign fire   = r_tok && i_step && r_en;
    assign expire = fire && at_one;
    assign sel    = i_cmd.valid && (i_cmd.addr == i_idx);

    assign o_tok  = r_tok;
    // this slot or a later one will expire when the token reaches it
    assign o_pend = (r_en && at_one) || i_pend;

    always_comb begin
        o_hit = i_hit;
        if (expire) begin
            o_hit.valid = 1'b1;
            o_hit.last  = !i_pend;
            o_hit.slot  = i_idx;
        end
    end

    always_comb begin
        n_en  = r_en;
        n_one = r_one;
        n_per = r_per;
        n_cnt = r_cnt;
        if (fire) begin
            if (at_one) begin
                n_cnt = r_per;
                if (r_one) begin
                    n_en = 1'b0;
                end
            end else begin
                n_cnt = r_cnt - COUNT_WIDTH'(1);
            end
        end else if (sel) begin
            case (i_cmd.kind)
                K_CREATE: begin
                    n_en  = 1'b0;
                    n_one = i_cmd.one;
                    n_per = i_cmd.ival;
                    n_cnt = i_cmd.ival;
                end
                K_SETIV: begin
                    n_per = i_cmd.ival;
                    n_cnt = i_cmd.ival;
                end
                K_START: begin
                    n_en = 1'b1;
                end
                K_STOP: begin
                    n_en = 1'b0;
                end
                K_RELOAD: begin
                    n_cnt = r_per;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
            r_en  <= 1'b0;
        end else begin
            if (i_step) begin
                r_tok <= i_tok;
            end
            r_en <= n_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_one <= n_one;
        r_per <= n_per;
        r_cnt <= n_cnt;
    end

endmodule

// ----- sim/periodic_oneshot_timer_bank_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_oneshot_timer_bank_unit_tb
// drives tick, create and timer commands into the timer bank, predicts the
// expiry and create events from a shadow copy of the bank, and checks each
// output word in order under random stalls on both sides and long receiver hold-offs
// ----------------------------------------------------------------------------
module periodic_oneshot_timer_bank_unit_tb;

    import pot_pkg::*;

    // kinds the bank must ignore
    localparam logic [2:0] KIND_RSVD_6 = 3'd6;
    localparam logic [2:0] KIND_RSVD_7 = 3'd7;

    localparam int SETTLE_CYCLES  = 4 * (NUM_TIMERS + 1) + 8;
    localparam int RX_HOLD_CYCLES = 150;

    typedef struct packed {
        logic [2:0]             kind;
        logic [IDX_W-1:0]       idx;
        logic [COUNT_WIDTH-1:0] ival;
        logic                   one;
    } t_timer_cmd;

    typedef struct packed {
        logic [1:0] ev;
        logic [2:0] slot;
        logic       last;
    } t_timer_event;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // command words waiting to be sent, and events still owed by the bank
    t_timer_cmd   cmd_backlog [$];
    t_timer_event owed_events [$];
    t_timer_cmd   cmd_on_bus;
    t_timer_event got_ev;
    t_timer_event want_ev;

    // shadow of the bank, updated as each command word is accepted
    logic [COUNT_WIDTH-1:0] shadow_period [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] shadow_count  [NUM_TIMERS];
    bit                     shadow_en     [NUM_TIMERS];
    bit                     shadow_one    [NUM_TIMERS];
    int                     shadow_used = 0;

    int gen_slots = 0;
    int events_predicted = 0;
    int fail_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int extra_rounds;

    periodic_oneshot_timer_bank_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic void predict_timer_events(t_timer_cmd c);
        t_timer_event evs [NUM_TIMERS];
        int n;
        int i;
        bit hit;
        n = 0;
        hit = (int'(c.idx) < shadow_used);
        case (c.kind)
            K_TICK: begin
                for (i = 0; i < shadow_used; i++) begin
                    if (shadow_en[i]) begin
                        shadow_count[i] = shadow_count[i] - 1'b1;
                        if (shadow_count[i] == '0) begin
                            shadow_count[i] = shadow_period[i];
                            if (shadow_one[i])
                                shadow_en[i] = 1'b0;
                            evs[n] = '{ev: EV_EXPIRED, slot: 3'(i), last: 1'b0};
                            n++;
                        end
                    end
                end
            end
            K_CREATE: begin
                if (shadow_used < NUM_TIMERS) begin
                    shadow_en[shadow_used]     = 1'b0;
                    shadow_period[shadow_used] = c.ival;
                    shadow_count[shadow_used]  = c.ival;
                    shadow_one[shadow_used]    = c.one;
                    evs[0] = '{ev: EV_CREATED, slot: 3'(shadow_used), last: 1'b0};
                    shadow_used++;
                end else begin
                    evs[0] = '{ev: EV_FULL, slot: 3'd0, last: 1'b0};
                end
                n = 1;
            end
            K_SETIV: begin
                if (hit) begin
                    shadow_period[c.idx] = c.ival;
                    shadow_count[c.idx]  = c.ival;
                end
            end
            K_START: begin
                if (hit)
                    shadow_en[c.idx] = 1'b1;
            end
            K_STOP: begin
                if (hit)
                    shadow_en[c.idx] = 1'b0;
            end
            K_RELOAD: begin
                if (hit)
                    shadow_count[c.idx] = shadow_period[c.idx];
            end
            default: begin
            end
        endcase
        for (i = 0; i < n; i++) begin
            evs[i].last = (i == n - 1);
            owed_events.push_back(evs[i]);
        end
        events_predicted += n;
    endfunction

    // sender: offers the next backlog word, holding it until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_timer_events(cmd_on_bus);
            if (!s_tvalid || s_tready) begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    cmd_on_bus = cmd_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_TDATA_W - IDX_W - COUNT_WIDTH - 1){1'b0}},
                                 cmd_on_bus.one, cmd_on_bus.ival, cmd_on_bus.idx};
                    s_tuser  <= cmd_on_bus.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left   <= RX_HOLD_CYCLES;
        end
    end

    // receiver: checks each event word against the oldest one owed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_ev = '{ev: m_tdata[1:0], slot: m_tdata[4:2], last: m_tlast};
                if (owed_events.size() == 0) begin
                    $error("unexpected event word: event_res %0d, slot %0d, last %0d",
                           got_ev.ev, got_ev.slot, got_ev.last);
                    fail_count++;
                end else begin
                    want_ev = owed_events.pop_front();
                    if (got_ev.ev !== want_ev.ev) begin
                        $error("event_res mismatch: expected %0d, actual %0d",
                               want_ev.ev, got_ev.ev);
                        fail_count++;
                    end
                    if (got_ev.slot !== want_ev.slot) begin
                        $error("slot mismatch: expected %0d, actual %0d",
                               want_ev.slot, got_ev.slot);
                        fail_count++;
                    end
                    if (got_ev.last !== want_ev.last) begin
                        $error("last mismatch: expected %0d, actual %0d",
                               want_ev.last, got_ev.last);
                        fail_count++;
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic push_cmd(logic [2:0] kind, logic [IDX_W-1:0] idx,
                            logic [COUNT_WIDTH-1:0] ival, logic one);
        cmd_backlog.push_back('{kind: kind, idx: idx, ival: ival, one: one});
        if (kind == K_CREATE && gen_slots < NUM_TIMERS)
            gen_slots++;
    endtask

    task automatic set_idle(int tx_pct, int rx_pct);
        tx_idle_pct <= tx_pct;
        rx_idle_pct <= rx_pct;
    endtask

    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || s_tvalid)
            @(posedge i_clk);
    endtask

    task automatic wait_quiet();
        wait_drained();
        while (owed_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly ticks and commands on live slots with short periods so timers
    // keep expiring; ignored words are not counted
    task automatic gen_random(int n_useful);
        int done;
        int roll;
        int vroll;
        logic [2:0]             kind;
        logic [IDX_W-1:0]       idx;
        logic [COUNT_WIDTH-1:0] ival;
        done = 0;
        while (done < n_useful) begin
            roll  = $urandom_range(99);
            vroll = $urandom_range(99);
            if (gen_slots > 0 && $urandom_range(9) < 8)
                idx = IDX_W'($urandom_range(gen_slots - 1));
            else
                idx = IDX_W'($urandom_range(NUM_TIMERS - 1));
            if (vroll < 75)
                ival = COUNT_WIDTH'($urandom_range(8, 1));
            else if (vroll < 85)
                ival = '0;
            else
                ival = COUNT_WIDTH'($urandom);
            if (roll < 40)
                kind = K_TICK;
            else if (roll < 48)
                kind = K_CREATE;
            else if (roll < 60)
                kind = K_SETIV;
            else if (roll < 78)
                kind = K_START;
            else if (roll < 85)
                kind = K_STOP;
            else if (roll < 95)
                kind = K_RELOAD;
            else
                kind = roll[0] ? KIND_RSVD_7 : KIND_RSVD_6;
            if (kind == K_TICK || kind == K_CREATE ||
                (kind <= K_RELOAD && int'(idx) < gen_slots))
                done++;
            push_cmd(kind, idx, ival, 1'($urandom_range(1)));
        end
    endtask

    initial begin
        set_idle(26, 84);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty bank, commands on unused slots, unknown kinds
        push_cmd(K_TICK, 3'd0, '0, 1'b0);
        push_cmd(K_START, 3'd0, '1, 1'b1);
        push_cmd(KIND_RSVD_6, 3'd7, '1, 1'b1);
        push_cmd(KIND_RSVD_7, 3'd0, '0, 1'b0);
        // period one, all-ones one-shot, zero period, period two one-shot
        push_cmd(K_CREATE, 3'd7, 32'd1, 1'b0);
        push_cmd(K_CREATE, 3'd0, '1, 1'b1);
        push_cmd(K_CREATE, 3'd0, '0, 1'b0);
        push_cmd(K_CREATE, 3'd0, 32'd2, 1'b1);
        for (int i = 0; i < 4; i++)
            push_cmd(K_START, 3'(i), '0, 1'b0);
        repeat (3) push_cmd(K_TICK, 3'd0, '0, 1'b0);
        push_cmd(K_SETIV, 3'd1, 32'd1, 1'b0);
        push_cmd(K_STOP, 3'd0, '0, 1'b0);
        push_cmd(K_TICK, 3'd0, '0, 1'b0);
        push_cmd(K_RELOAD, 3'd3, '0, 1'b0);
        push_cmd(K_START, 3'd3, '0, 1'b0);
        push_cmd(K_SETIV, 3'd7, '1, 1'b1);
        push_cmd(K_RELOAD, 3'd6, '0, 1'b0);
        push_cmd(K_STOP, 3'd5, '0, 1'b0);
        repeat (2) push_cmd(K_TICK, 3'd0, '0, 1'b0);
        wait_drained();

        // receiver holds off while the sender keeps offering words
        hold_requests <= hold_requests + 1;
        gen_random(38);
        wait_drained();
        wait_quiet();

        set_idle(84, 26);
        gen_random(38);
        wait_drained();

        set_idle(0, 0);
        hold_requests <= hold_requests + 1;
        while (gen_slots < NUM_TIMERS)
            push_cmd(K_CREATE, 3'd0, COUNT_WIDTH'($urandom_range(6, 1)),
                     1'($urandom_range(1)));
        push_cmd(K_CREATE, 3'd0, 32'd3, 1'b0);
        gen_random(38);
        wait_drained();

        extra_rounds = 0;
        while (events_predicted < 48 && extra_rounds < 30) begin
            gen_random(10);
            wait_drained();
            extra_rounds++;
        end

        wait_quiet();
        if (fail_count == 0 && owed_events.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
